// ----- design/qrt_pkg.sv -----
// ----------------------------------------------------------------------------
// qrt_pkg
// Shared widths, vector types and register indexes for the quaternion
// rigid transform core.
// ----------------------------------------------------------------------------
package qrt_pkg;

   localparam int VW   = 32;  // Q16.16 coordinate width
   localparam int QW   = 32;  // Q2.30 quaternion component width
   localparam int PAW  = 64;  // exact sum of three Q2.30 x Q16.16 products
   localparam int AW   = 34;  // q x v + w*v after rounding, kept wide
   localparam int PTW  = 66;  // exact sum of two Q2.30 x (AW) products
   localparam int TW   = 36;  // 2*(q x a) after rounding
   localparam int RW   = 38;  // v + t + translation before saturation
   localparam int IDXW = 3;   // register index width

   localparam logic signed [QW-1:0] Q_ONE = 32'sh4000_0000;
   localparam logic signed [QW-1:0] Q_MIN = 32'shC000_0000;

   // half an output LSB for each rounding step
   localparam logic signed [PAW-1:0] RND_A = 64'sh0000_0000_2000_0000;
   localparam logic signed [PTW-1:0] RND_T = 66'sh0_0000_0000_1000_0000;

   typedef enum logic [IDXW-1:0] {
      REG_ROT_W   = 3'd0,
      REG_ROT_X   = 3'd1,
      REG_ROT_Y   = 3'd2,
      REG_ROT_Z   = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5,
      REG_SHIFT_Z = 3'd6
   } reg_idx_type;

   typedef struct packed {
      logic signed [QW-1:0] w;
      logic signed [QW-1:0] x;
      logic signed [QW-1:0] y;
      logic signed [QW-1:0] z;
   } quat_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic signed [VW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic signed [AW-1:0] x;
      logic signed [AW-1:0] y;
      logic signed [AW-1:0] z;
   } avec_type;

   typedef struct packed {
      logic signed [TW-1:0] x;
      logic signed [TW-1:0] y;
      logic signed [TW-1:0] z;
   } tvec_type;

endpackage

// ----- design/qrt_csr.sv -----
// ----------------------------------------------------------------------------
// qrt_csr
// Configuration registers: quaternion (clamped to [-1, 1] on write) and
// translation.
// ----------------------------------------------------------------------------
module qrt_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   output qrt_pkg::quat_type    quat,
   output qrt_pkg::vec_type     shift
);
   import qrt_pkg::*;

   quat_type             quat_ff;
   vec_type              shift_ff;
   logic signed [QW-1:0] clamp_in;

   assign csr_ready = 1'b1;

   // hold quaternion components inside [-1, 1]
   always_comb begin
      if ($signed(csr_data) > Q_ONE) begin
         clamp_in = Q_ONE;
      end else if ($signed(csr_data) < Q_MIN) begin
         clamp_in = Q_MIN;
      end else begin
         clamp_in = $signed(csr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quat_ff  <= '{w: Q_ONE, x: '0, y: '0, z: '0};
         shift_ff <= '0;
      end else if (csr_valid) begin
         unique case (reg_idx_type'(csr_index))
            REG_ROT_W:   quat_ff.w  <= clamp_in;
            REG_ROT_X:   quat_ff.x  <= clamp_in;
            REG_ROT_Y:   quat_ff.y  <= clamp_in;
            REG_ROT_Z:   quat_ff.z  <= clamp_in;
            REG_SHIFT_X: shift_ff.x <= $signed(csr_data);
            REG_SHIFT_Y: shift_ff.y <= $signed(csr_data);
            REG_SHIFT_Z: shift_ff.z <= $signed(csr_data);
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   assign quat  = quat_ff;
   assign shift = shift_ff;

endmodule

// ----- design/qrt_stage_a.sv -----
// ----------------------------------------------------------------------------
// qrt_stage_a
// Two pipeline stages computing a = q x v + w*v: nine products, then
// exact three-term sums rounded from Q2.30 x Q16.16 to Q18.16.
// ----------------------------------------------------------------------------
module qrt_stage_a (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qrt_pkg::quat_type    quat,
   input  qrt_pkg::vec_type     v_in,
   input  logic                 dir_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qrt_pkg::avec_type    a_out,
   output qrt_pkg::vec_type     v_out,
   output logic                 dir_out
);
   import qrt_pkg::*;

   logic signed [PAW-1:0] prod_ff [9];
   logic signed [PAW-1:0] prod_in [9];
   vec_type               v1_ff, v2_ff;
   logic                  dir1_ff, dir2_ff;
   logic                  vld1_ff, vld2_ff;
   logic                  adv1, adv2;
   logic signed [PAW-1:0] sum_x, sum_y, sum_z;
   avec_type              a_in, a_ff;

   assign adv2     = !vld2_ff || out_ready;
   assign adv1     = !vld1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      prod_in[0] = quat.y * v_in.z;
      prod_in[1] = quat.z * v_in.y;
      prod_in[2] = quat.w * v_in.x;
      prod_in[3] = quat.z * v_in.x;
      prod_in[4] = quat.x * v_in.z;
      prod_in[5] = quat.w * v_in.y;
      prod_in[6] = quat.x * v_in.y;
      prod_in[7] = quat.y * v_in.x;
      prod_in[8] = quat.w * v_in.z;
   end

   // sums stay below 2^63, so 64 bits hold them exactly
   always_comb begin
      sum_x  = prod_ff[0] - prod_ff[1] + prod_ff[2] + RND_A;
      sum_y  = prod_ff[3] - prod_ff[4] + prod_ff[5] + RND_A;
      sum_z  = prod_ff[6] - prod_ff[7] + prod_ff[8] + RND_A;
      a_in.x = sum_x[PAW-1:PAW-AW];
      a_in.y = sum_y[PAW-1:PAW-AW];
      a_in.z = sum_z[PAW-1:PAW-AW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            vld1_ff <= in_valid;
         end
         if (adv2) begin
            vld2_ff <= vld1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff <= prod_in;
         v1_ff   <= v_in;
         dir1_ff <= dir_in;
      end
      if (adv2) begin
         a_ff    <= a_in;
         v2_ff   <= v1_ff;
         dir2_ff <= dir1_ff;
      end
   end

   assign out_valid = vld2_ff;
   assign a_out     = a_ff;
   assign v_out     = v2_ff;
   assign dir_out   = dir2_ff;

endmodule

// ----- design/qrt_stage_t.sv -----
// ----------------------------------------------------------------------------
// qrt_stage_t
// Two pipeline stages computing t = 2*(q x a): six products, then exact
// two-term differences rounded with the factor two folded into the shift.
// ----------------------------------------------------------------------------
module qrt_stage_t (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qrt_pkg::quat_type    quat,
   input  qrt_pkg::avec_type    a_in,
   input  qrt_pkg::vec_type     v_in,
   input  logic                 dir_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qrt_pkg::tvec_type    t_out,
   output qrt_pkg::vec_type     v_out,
   output logic                 dir_out
);
   import qrt_pkg::*;

   logic signed [PTW-1:0] prod_ff [6];
   logic signed [PTW-1:0] prod_in [6];
   vec_type               v1_ff, v2_ff;
   logic                  dir1_ff, dir2_ff;
   logic                  vld1_ff, vld2_ff;
   logic                  adv1, adv2;
   logic signed [PTW-1:0] sum_x, sum_y, sum_z;
   tvec_type              t_in, t_ff;

   assign adv2     = !vld2_ff || out_ready;
   assign adv1     = !vld1_ff || adv2;
   assign in_ready = adv1;

   always_comb begin
      prod_in[0] = quat.y * a_in.z;
      prod_in[1] = quat.z * a_in.y;
      prod_in[2] = quat.z * a_in.x;
      prod_in[3] = quat.x * a_in.z;
      prod_in[4] = quat.x * a_in.y;
      prod_in[5] = quat.y * a_in.x;
   end

   // divide by 2^29 with round half up; result fits in TW bits
   always_comb begin
      sum_x  = prod_ff[0] - prod_ff[1] + RND_T;
      sum_y  = prod_ff[2] - prod_ff[3] + RND_T;
      sum_z  = prod_ff[4] - prod_ff[5] + RND_T;
      t_in.x = sum_x[TW+28:29];
      t_in.y = sum_y[TW+28:29];
      t_in.z = sum_z[TW+28:29];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else begin
         if (adv1) begin
            vld1_ff <= in_valid;
         end
         if (adv2) begin
            vld2_ff <= vld1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         prod_ff <= prod_in;
         v1_ff   <= v_in;
         dir1_ff <= dir_in;
      end
      if (adv2) begin
         t_ff    <= t_in;
         v2_ff   <= v1_ff;
         dir2_ff <= dir1_ff;
      end
   end

   assign out_valid = vld2_ff;
   assign t_out     = t_ff;
   assign v_out     = v2_ff;
   assign dir_out   = dir2_ff;

endmodule

// ----- design/qrt_place.sv -----
// ----------------------------------------------------------------------------
// qrt_place
// Final stage: add the rotation term and, for points, the translation,
// then saturate each component to Q16.16 into the output register.
// ----------------------------------------------------------------------------
module qrt_place (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  qrt_pkg::vec_type     shift,
   input  qrt_pkg::tvec_type    t_in,
   input  qrt_pkg::vec_type     v_in,
   input  logic                 dir_in,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qrt_pkg::vec_type     r_out,
   output logic                 sat_out
);
   import qrt_pkg::*;

   logic signed [RW-1:0] sx, sy, sz;
   logic signed [RW-1:0] rx, ry, rz;
   logic [2:0]           hi, lo;
   vec_type              r_in, r_ff;
   logic                 sat_in, sat_ff;
   logic                 vld_ff;
   logic                 adv;

   assign adv      = !vld_ff || out_ready;
   assign in_ready = adv;

   always_comb begin
      // directions skip the translation
      sx = dir_in ? '0 : RW'(shift.x);
      sy = dir_in ? '0 : RW'(shift.y);
      sz = dir_in ? '0 : RW'(shift.z);
      rx = RW'(v_in.x) + RW'(t_in.x) + sx;
      ry = RW'(v_in.y) + RW'(t_in.y) + sy;
      rz = RW'(v_in.z) + RW'(t_in.z) + sz;

      hi[0] = !rx[RW-1] && (rx[RW-2:VW-1] != '0);
      lo[0] =  rx[RW-1] && (rx[RW-2:VW-1] != '1);
      hi[1] = !ry[RW-1] && (ry[RW-2:VW-1] != '0);
      lo[1] =  ry[RW-1] && (ry[RW-2:VW-1] != '1);
      hi[2] = !rz[RW-1] && (rz[RW-2:VW-1] != '0);
      lo[2] =  rz[RW-1] && (rz[RW-2:VW-1] != '1);

      r_in.x = hi[0] ? {1'b0, {(VW-1){1'b1}}} : lo[0] ? {1'b1, {(VW-1){1'b0}}} : rx[VW-1:0];
      r_in.y = hi[1] ? {1'b0, {(VW-1){1'b1}}} : lo[1] ? {1'b1, {(VW-1){1'b0}}} : ry[VW-1:0];
      r_in.z = hi[2] ? {1'b0, {(VW-1){1'b1}}} : lo[2] ? {1'b1, {(VW-1){1'b0}}} : rz[VW-1:0];
      sat_in = |(hi | lo);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff   <= r_in;
         sat_ff <= sat_in;
      end
   end

   assign out_valid = vld_ff;
   assign r_out     = r_ff;
   assign sat_out   = sat_ff;

endmodule

// ----- design/quaternion_rigid_transform_core.sv -----
// ----------------------------------------------------------------------------
// quaternion_rigid_transform_core
// Rotates a Q16.16 point or direction by a Q2.30 quaternion and adds a
// Q16.16 translation to points, saturating the result.
// ----------------------------------------------------------------------------
// A five-stage pipeline that takes one transaction every cycle while the
// output side does not stall: two stages form q x v + w*v (products, then
// rounded sum), two form 2*(q x a) the same way, and the last adds v, the
// rotation term and, for points, the translation, then saturates into the
// output register. The 32x32 and 32x34 products of the first and third
// stages set the clock period. Each stage holds its own valid bit and fills
// any bubble ahead of it, so a stall on rsp_ready loses or repeats nothing.
// Quaternion components are clamped to [-1, 1] when written; configuration
// writes are meant to happen while no transaction is in flight.
module quaternion_rigid_transform_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [31:0] req_in_x,
   input  logic [31:0] req_in_y,
   input  logic [31:0] req_in_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_out_x,
   output logic [31:0] rsp_out_y,
   output logic [31:0] rsp_out_z,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import qrt_pkg::*;

   quat_type  quat;
   vec_type   shift;
   vec_type   v_req;
   avec_type  a_vec;
   vec_type   v_a, v_t;
   logic      dir_a, dir_t;
   logic      vld_a, rdy_a;
   tvec_type  t_vec;
   logic      vld_t, rdy_t;
   vec_type   r_vec;

   assign v_req.x = $signed(req_in_x);
   assign v_req.y = $signed(req_in_y);
   assign v_req.z = $signed(req_in_z);

   qrt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .quat      (quat),
      .shift     (shift)
   );

   qrt_stage_a u_stage_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .quat      (quat),
      .v_in      (v_req),
      .dir_in    (req_action),
      .out_valid (vld_a),
      .out_ready (rdy_a),
      .a_out     (a_vec),
      .v_out     (v_a),
      .dir_out   (dir_a)
   );

   qrt_stage_t u_stage_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_a),
      .in_ready  (rdy_a),
      .quat      (quat),
      .a_in      (a_vec),
      .v_in      (v_a),
      .dir_in    (dir_a),
      .out_valid (vld_t),
      .out_ready (rdy_t),
      .t_out     (t_vec),
      .v_out     (v_t),
      .dir_out   (dir_t)
   );

   qrt_place u_place (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_t),
      .in_ready  (rdy_t),
      .shift     (shift),
      .t_in      (t_vec),
      .v_in      (v_t),
      .dir_in    (dir_t),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .r_out     (r_vec),
      .sat_out   (rsp_saturated)
   );

   assign rsp_out_x = r_vec.x;
   assign rsp_out_y = r_vec.y;
   assign rsp_out_z = r_vec.z;

endmodule

// ----- verif/quaternion_rigid_transform_core_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_rigid_transform_core_tb
// Self-checking bench for the quaternion rigid transform core. A short table
// of directed transactions covers field extremes, identity and half-turn
// rotations, saturation, clamped quaternions and the unused register index.
// Random transactions follow under randomly chosen placements, in four
// flow-control phases. Directed rows with a listed result are checked against
// it; every other result against a bit-exact fixed-point model kept in the bench.
// ----------------------------------------------------------------------------
module quaternion_rigid_transform_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import qrt_pkg::*;

   localparam logic       ACT_POINT   = 1'b0;
   localparam logic       ACT_DIR     = 1'b1;
   localparam logic [2:0] REG_UNUSED  = 3'd7;
   localparam int         RAND_PHASE  = 325;
   localparam int         RESET_EVERY = 65;
   localparam int         CYCLE_LIMIT = 600000;

   typedef struct packed {
      vec_type v;
      logic    sat;
   } xform_type;

   typedef struct packed {
      logic [2:0]  idx;
      logic [31:0] data;
   } reg_write_type;

   typedef struct packed {
      logic        is_csr;
      logic [2:0]  idx;
      logic [31:0] data;
      logic        act;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        typed;
      xform_type   known;
   } plan_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [31:0] req_in_x = '0;
   logic [31:0] req_in_y = '0;
   logic [31:0] req_in_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [31:0] rsp_out_z;
   logic        rsp_saturated;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   logic [31:0]   xform_reg [0:6];
   xform_type     expected_xforms [$];
   reg_write_type reg_batch [$];
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            errors = 0;
   int            items_sent = 0;
   int            dirs_sent = 0;
   int            results_seen = 0;
   int            sat_seen = 0;
   int            settings_done = 0;
   int            cycle_count = 0;

   quaternion_rigid_transform_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_in_x      (req_in_x),
      .req_in_y      (req_in_y),
      .req_in_z      (req_in_z),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_saturated (rsp_saturated),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quaternion_rigid_transform_core_tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Fixed-point model
   // ------------------------------------------------------------------------
   function automatic logic signed [95:0] clamp_unit(input logic [31:0] r);
      logic signed [95:0] q;
      q = $signed(r);
      if (q > Q_ONE)
         q = Q_ONE;
      else if (q < Q_MIN)
         q = Q_MIN;
      return q;
   endfunction

   // divide by 2^n, round to nearest with ties toward +infinity
   function automatic logic signed [95:0] round_shift(input logic signed [95:0] s,
                                                      input int unsigned n);
      return (s + (96'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic xform_type rotate_translate(input logic act, input logic [31:0] px,
                                                  input logic [31:0] py,
                                                  input logic [31:0] pz);
      logic signed [95:0] w, qx, qy, qz, vx, vy, vz, ax, ay, az, tx, ty, tz;
      logic signed [95:0] r [3];
      logic [31:0]        o [3];
      xform_type          res;
      w  = clamp_unit(xform_reg[REG_ROT_W]);
      qx = clamp_unit(xform_reg[REG_ROT_X]);
      qy = clamp_unit(xform_reg[REG_ROT_Y]);
      qz = clamp_unit(xform_reg[REG_ROT_Z]);
      vx = $signed(px);
      vy = $signed(py);
      vz = $signed(pz);
      ax = round_shift(qy * vz - qz * vy + w * vx, 30);
      ay = round_shift(qz * vx - qx * vz + w * vy, 30);
      az = round_shift(qx * vy - qy * vx + w * vz, 30);
      // factor two folded into the shift
      tx = round_shift(qy * az - qz * ay, 29);
      ty = round_shift(qz * ax - qx * az, 29);
      tz = round_shift(qx * ay - qy * ax, 29);
      r[0] = vx + tx;
      r[1] = vy + ty;
      r[2] = vz + tz;
      if (act == ACT_POINT) begin
         r[0] = r[0] + $signed(xform_reg[REG_SHIFT_X]);
         r[1] = r[1] + $signed(xform_reg[REG_SHIFT_Y]);
         r[2] = r[2] + $signed(xform_reg[REG_SHIFT_Z]);
      end
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (r[i] > 96'sh7FFF_FFFF) begin
            o[i] = 32'h7FFF_FFFF;
            res.sat = 1'b1;
         end else if (r[i] < -96'sh8000_0000) begin
            o[i] = 32'h8000_0000;
            res.sat = 1'b1;
         end else begin
            o[i] = r[i][31:0];
         end
      end
      res.v.x = o[0];
      res.v.y = o[1];
      res.v.z = o[2];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic plan_row_type cfg_row(input logic [2:0] idx, input logic [31:0] d);
      plan_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.idx = idx;
      r.data = d;
      return r;
   endfunction

   function automatic plan_row_type vec_row(input logic act, input logic [31:0] x,
                                            input logic [31:0] y, input logic [31:0] z);
      plan_row_type r;
      r = '0;
      r.act = act;
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic act, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z,
                                              input logic [31:0] ex, input logic [31:0] ey,
                                              input logic [31:0] ez, input logic es);
      plan_row_type r;
      r = vec_row(act, x, y, z);
      r.typed = 1'b1;
      r.known.v.x = ex;
      r.known.v.y = ey;
      r.known.v.z = ez;
      r.known.sat = es;
      return r;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2, 3, 4: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
         default:    return $urandom;
      endcase
   endfunction

   task automatic push_item(input logic act, input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z, input logic typed, input xform_type known);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_in_x   <= x;
      req_in_y   <= y;
      req_in_z   <= z;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_xforms.push_back(typed ? known : rotate_translate(act, x, y, z));
      items_sent++;
      if (act == ACT_DIR)
         dirs_sent++;
   endtask

   // hold the sender off until the pipeline has emptied
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_xforms.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic flush_regs();
      reg_write_type wr;
      settle();
      while (reg_batch.size() != 0) begin
         wr = reg_batch.pop_front();
         csr_valid <= 1'b1;
         csr_index <= wr.idx;
         csr_data  <= wr.data;
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         if (wr.idx != REG_UNUSED)
            xform_reg[wr.idx] = wr.data;
      end
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall, in-order check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      xform_type want;
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_xforms.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected transaction: x=%h y=%h z=%h sat=%b",
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
         end else begin
            want = expected_xforms.pop_front();
            results_seen++;
            if (want.sat)
               sat_seen++;
            if (rsp_out_x !== want.v.x || rsp_out_y !== want.v.y ||
                rsp_out_z !== want.v.z || rsp_saturated !== want.sat) begin
               errors++;
               if (errors <= 10)
                  $display({"mismatch on transaction %0d: expected x=%h y=%h z=%h sat=%b,",
                            " got x=%h y=%h z=%h sat=%b"},
                           results_seen, want.v.x, want.v.y, want.v.z, want.sat,
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      plan_row_type plan [$];
      logic [31:0]  qv [4];
      real          comp [4];
      real          norm;
      int           kind;
      int           idle_send [4];
      int           idle_recv [4];
      xform_type    none;

      none = '0;
      idle_send = '{0, 88, 0, 9};
      idle_recv = '{0, 0, 88, 9};
      for (int i = 0; i < 7; i++)
         xform_reg[i] = '0;
      xform_reg[REG_ROT_W] = Q_ONE;

      plan = '{
         // identity after reset
         known_row(ACT_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0),
         known_row(ACT_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0),
         known_row(ACT_DIR, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000, 1'b0),
         // extreme translation: points clip, directions ignore it
         cfg_row(REG_SHIFT_X, 32'h7FFF_FFFF),
         cfg_row(REG_SHIFT_Y, 32'h8000_0000),
         cfg_row(REG_SHIFT_Z, 32'h0001_0000),
         known_row(ACT_POINT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1),
         known_row(ACT_DIR, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0),
         known_row(ACT_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0),
         // half turn about x negates y and z
         cfg_row(REG_ROT_W, 32'h0000_0000),
         cfg_row(REG_ROT_X, 32'h4000_0000),
         cfg_row(REG_SHIFT_X, 32'h0000_0000),
         cfg_row(REG_SHIFT_Y, 32'h0000_0000),
         cfg_row(REG_SHIFT_Z, 32'h0000_0000),
         known_row(ACT_POINT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   32'h0001_0000, 32'hFFFE_0000, 32'hFFFD_0000, 1'b0),
         known_row(ACT_DIR, 32'h0000_0005, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0005, 32'h7FFF_FFFF, 32'h8000_0001, 1'b1),
         // scalar -1 is the identity rotation
         cfg_row(REG_ROT_W, 32'hC000_0000),
         cfg_row(REG_ROT_X, 32'h0000_0000),
         known_row(ACT_POINT, 32'h0001_2345, 32'hFFFF_FFF9, 32'h7FFF_FFFF,
                   32'h0001_2345, 32'hFFFF_FFF9, 32'h7FFF_FFFF, 1'b0),
         // write to the unused index must leave the placement alone
         cfg_row(REG_UNUSED, 32'hDEAD_BEEF),
         known_row(ACT_DIR, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0),
         // out-of-range components clamp to +-1, non-unit result
         cfg_row(REG_ROT_W, 32'h7FFF_FFFF),
         cfg_row(REG_ROT_X, 32'h8000_0000),
         cfg_row(REG_ROT_Y, 32'h4000_0000),
         cfg_row(REG_ROT_Z, 32'hC000_0000),
         vec_row(ACT_POINT, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000),
         vec_row(ACT_DIR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
         vec_row(ACT_POINT, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF),
         // quarter turn about z with a fractional translation
         cfg_row(REG_ROT_W, 32'h2D41_3CCD),
         cfg_row(REG_ROT_X, 32'h0000_0000),
         cfg_row(REG_ROT_Y, 32'h0000_0000),
         cfg_row(REG_ROT_Z, 32'h2D41_3CCD),
         cfg_row(REG_SHIFT_X, 32'h0001_8000),
         cfg_row(REG_SHIFT_Y, 32'hFFFE_8000),
         cfg_row(REG_SHIFT_Z, 32'h0000_0001),
         vec_row(ACT_POINT, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000),
         vec_row(ACT_DIR, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000),
         vec_row(ACT_POINT, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001),
         vec_row(ACT_POINT, 32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000),
         // all components at -1, translation at both ends
         cfg_row(REG_ROT_W, 32'hC000_0000),
         cfg_row(REG_ROT_X, 32'hC000_0000),
         cfg_row(REG_ROT_Y, 32'hC000_0000),
         cfg_row(REG_ROT_Z, 32'hC000_0000),
         cfg_row(REG_SHIFT_X, 32'h8000_0000),
         cfg_row(REG_SHIFT_Y, 32'h7FFF_FFFF),
         cfg_row(REG_SHIFT_Z, 32'h8000_0000),
         vec_row(ACT_POINT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000),
         vec_row(ACT_POINT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF),
         vec_row(ACT_DIR, 32'h0000_0003, 32'hFFFF_FFFD, 32'h0000_0001),
         // all components at +1
         cfg_row(REG_ROT_W, 32'h4000_0000),
         cfg_row(REG_ROT_X, 32'h4000_0000),
         cfg_row(REG_ROT_Y, 32'h4000_0000),
         cfg_row(REG_ROT_Z, 32'h4000_0000),
         vec_row(ACT_DIR, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003),
         vec_row(ACT_POINT, 32'h4000_0000, 32'hC000_0000, 32'h0000_0000)
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            reg_batch.push_back('{idx: plan[i].idx, data: plan[i].data});
         end else begin
            if (reg_batch.size() != 0)
               flush_regs();
            push_item(plan[i].act, plan[i].x, plan[i].y, plan[i].z,
                      plan[i].typed, plan[i].known);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_send[ph];
         recv_stall_pct = idle_recv[ph];
         for (int k = 0; k < RAND_PHASE; k++) begin
            if (k % RESET_EVERY == 0) begin
               kind = $urandom_range(3);
               if (kind == 0) begin
                  // random unit quaternion
                  norm = 0.0;
                  for (int c = 0; c < 4; c++) begin
                     comp[c] = real'(int'($urandom_range(2000000)) - 1000000);
                     norm = norm + comp[c] * comp[c];
                  end
                  norm = $sqrt(norm);
                  if (norm < 1.0) begin
                     comp = '{1.0, 0.0, 0.0, 0.0};
                     norm = 1.0;
                  end
               end
               for (int c = 0; c < 4; c++) begin
                  case (kind)
                     0: qv[c] = 32'($rtoi(comp[c] / norm * 1073741824.0));
                     1: qv[c] = $urandom_range(32'h8000_0000) - 32'h4000_0000;
                     2: qv[c] = $urandom;
                     default: begin
                        case ($urandom_range(2))
                           0:       qv[c] = Q_MIN;
                           1:       qv[c] = '0;
                           default: qv[c] = Q_ONE;
                        endcase
                     end
                  endcase
                  reg_batch.push_back('{idx: reg_idx_type'(REG_ROT_W + c), data: qv[c]});
               end
               if ($urandom_range(1)) begin
                  reg_batch.push_back('{idx: REG_SHIFT_X, data: $urandom});
                  reg_batch.push_back('{idx: REG_SHIFT_Y, data: $urandom});
                  reg_batch.push_back('{idx: REG_SHIFT_Z, data: $urandom});
               end else begin
                  reg_batch.push_back('{idx: REG_SHIFT_X,
                                        data: $urandom_range(32'h0020_0000) - 32'h0010_0000});
                  reg_batch.push_back('{idx: REG_SHIFT_Y,
                                        data: $urandom_range(32'h0020_0000) - 32'h0010_0000});
                  reg_batch.push_back('{idx: REG_SHIFT_Z,
                                        data: $urandom_range(32'h0020_0000) - 32'h0010_0000});
               end
               if ($urandom_range(3) == 0)
                  reg_batch.push_back('{idx: REG_UNUSED, data: $urandom});
               flush_regs();
            end
            push_item(logic'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord(),
                      1'b0, none);
         end
      end

      settle();
      if (expected_xforms.size() != 0)
         errors++;

      $display("covered %0d transactions (%0d directions, %0d saturated) under %0d placements",
               items_sent, dirs_sent, sat_seen, settings_done);
      $display("flow control: free-running, sender gaps, receiver stalls, both; %0d checked",
               results_seen);
      if (errors == 0)
         $display("quaternion_rigid_transform_core_tb: done, clean");
      else
         $display("quaternion_rigid_transform_core_tb: done, errors");
      $finish;
   end

endmodule
